// ===== sv/cpualu_pkg.sv =====
// Package: operation codes and shared types of the 8-bit CPU ALU.
`default_nettype none
package cpualu_pkg;

  typedef logic [5:0] op_t;

  localparam op_t OP_ADD    = 6'd0;
  localparam op_t OP_ADC    = 6'd1;
  localparam op_t OP_SUB    = 6'd2;
  localparam op_t OP_SBC    = 6'd3;
  localparam op_t OP_AND    = 6'd4;
  localparam op_t OP_XOR    = 6'd5;
  localparam op_t OP_OR     = 6'd6;
  localparam op_t OP_CP     = 6'd7;
  localparam op_t OP_INC    = 6'd8;
  localparam op_t OP_DEC    = 6'd9;
  localparam op_t OP_RLC    = 6'd10;
  localparam op_t OP_RRC    = 6'd11;
  localparam op_t OP_RL     = 6'd12;
  localparam op_t OP_RR     = 6'd13;
  localparam op_t OP_SLA    = 6'd14;
  localparam op_t OP_SRA    = 6'd15;
  localparam op_t OP_SWAP   = 6'd16;
  localparam op_t OP_SRL    = 6'd17;
  localparam op_t OP_BIT    = 6'd18;
  localparam op_t OP_RES    = 6'd19;
  localparam op_t OP_SET    = 6'd20;
  localparam op_t OP_DAA    = 6'd21;
  localparam op_t OP_CPL    = 6'd22;
  localparam op_t OP_CCF    = 6'd23;
  localparam op_t OP_SCF    = 6'd24;
  localparam op_t OP_RLCA   = 6'd25;
  localparam op_t OP_RRCA   = 6'd26;
  localparam op_t OP_RLA    = 6'd27;
  localparam op_t OP_RRA    = 6'd28;
  localparam op_t OP_ADD16  = 6'd29;
  localparam op_t OP_SPOFS  = 6'd30;
  localparam op_t OP_INC16  = 6'd31;
  localparam op_t OP_DEC16  = 6'd32;

  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [3:0] BCD_MAX   = 4'h9;

  // result of the byte logic / shift unit
  typedef struct packed {
    logic [7:0] value;
    logic       carry;
  } bitop_res_t;

endpackage
`default_nettype wire

// ===== sv/cpualu_bitops.sv =====
// Byte logic, rotate, shift and single-bit unit of the ALU.
`default_nettype none
module cpualu_bitops
  import cpualu_pkg::*;
(
  input  wire op_t        op,
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [2:0] bit_sel,
  input  wire logic       carry_in,
  output bitop_res_t      res
);

  logic [7:0] mask;

  assign mask = 8'd1 << bit_sel;

  always_comb begin
    res.value = a;
    res.carry = carry_in;
    case (op)
      OP_AND:  res.value = a & b;
      OP_XOR:  res.value = a ^ b;
      OP_OR:   res.value = a | b;
      OP_RLC, OP_RLCA: begin
        res.value = {a[6:0], a[7]};
        res.carry = a[7];
      end
      OP_RRC, OP_RRCA: begin
        res.value = {a[0], a[7:1]};
        res.carry = a[0];
      end
      OP_RL, OP_RLA: begin
        res.value = {a[6:0], carry_in};
        res.carry = a[7];
      end
      OP_RR, OP_RRA: begin
        res.value = {carry_in, a[7:1]};
        res.carry = a[0];
      end
      OP_SLA: begin
        res.value = {a[6:0], 1'b0};
        res.carry = a[7];
      end
      OP_SRA: begin
        res.value = {a[7], a[7:1]};
        res.carry = a[0];
      end
      OP_SWAP: begin
        res.value = {a[3:0], a[7:4]};
        res.carry = 1'b0;
      end
      OP_SRL: begin
        res.value = {1'b0, a[7:1]};
        res.carry = a[0];
      end
      OP_RES:  res.value = a & ~mask;
      OP_SET:  res.value = a | mask;
      OP_CPL:  res.value = ~a;
      default: res.value = a;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/cpu_alu_with_flags.sv =====
// Top level: pipelined 8/16-bit ALU with Z, N, H and C flags on stream ports.
//
// One operation enters per cycle unless stalled; its result leaves when the
// output side is ready. Stage one latches the item and sets up the adder
// operands (subtract as add of the complement, the decimal-adjust correction,
// sign extension of the stack offset); stage two runs the single 17-bit adder
// and the byte logic/shift unit; stage three selects the result, detects zero
// and forms the flags into the output register. A stall on the output holds
// every stage in place; an empty stage still takes a new item.
`default_nettype none
module cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: req_type[5:0], operand_a[21:6], operand_b[37:22], bit_index[40:38],
  //           zero_in[41], subtract_in[42], half_carry_in[43], carry_in[44], zero[47:45]
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // out_tdata: result[15:0], write_result[16], zero_out[17], subtract_out[18],
  //            half_carry_out[19], carry_out[20], zero[23:21]
  output      logic [23:0] out_tdata,
  output      logic        out_tvalid,
  input  wire logic        out_tready
);

  // input fields
  op_t         in_op;
  logic [15:0] in_a;
  logic [15:0] in_b;
  logic [2:0]  in_bi;
  logic [3:0]  in_flags;   // {c, h, n, z}

  assign in_op    = in_tdata[5:0];
  assign in_a     = in_tdata[21:6];
  assign in_b     = in_tdata[37:22];
  assign in_bi    = in_tdata[40:38];
  assign in_flags = in_tdata[44:41];

  // handshake chain
  logic v1_r, v2_r, v3_r;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready   = !v3_r || out_tready;
  assign s2_ready   = !v2_r || s3_ready;
  assign s1_ready   = !v1_r || s2_ready;
  assign in_tready  = s1_ready;
  assign out_tvalid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (s1_ready) v1_r <= in_tvalid;
      if (s2_ready) v2_r <= v1_r;
      if (s3_ready) v3_r <= v2_r;
    end
  end

  // ---------------- stage one: operand setup ----------------
  logic [15:0] x_nxt, y_nxt;
  logic        cin_nxt;
  logic        daa_c_nxt;
  logic [7:0]  daa_corr;
  logic [7:0]  a8_in, b8_in;
  logic        zi, ni, hi, ci;

  assign a8_in = in_a[7:0];
  assign b8_in = in_b[7:0];
  assign zi    = in_flags[0];
  assign ni    = in_flags[1];
  assign hi    = in_flags[2];
  assign ci    = in_flags[3];

  always_comb begin
    daa_c_nxt = ci || (!ni && (a8_in > DAA_LIMIT));
    daa_corr  = (daa_c_nxt ? DAA_HI : 8'h00) |
                ((hi || (!ni && (a8_in[3:0] > BCD_MAX))) ? DAA_LO : 8'h00);
    x_nxt   = {8'h00, a8_in};
    y_nxt   = 16'h0000;
    cin_nxt = 1'b0;
    case (in_op)
      OP_ADD: y_nxt = {8'h00, b8_in};
      OP_ADC: begin
        y_nxt   = {8'h00, b8_in};
        cin_nxt = ci;
      end
      OP_SUB, OP_CP: begin
        y_nxt   = {8'h00, ~b8_in};
        cin_nxt = 1'b1;
      end
      OP_SBC: begin
        y_nxt   = {8'h00, ~b8_in};
        cin_nxt = !ci;
      end
      OP_INC: cin_nxt = 1'b1;
      OP_DEC: y_nxt = 16'h00FF;
      OP_DAA: begin
        y_nxt   = {8'h00, (ni ? ~daa_corr : daa_corr)};
        cin_nxt = ni;
      end
      OP_ADD16: begin
        x_nxt = in_a;
        y_nxt = in_b;
      end
      OP_SPOFS: begin
        x_nxt = in_a;
        y_nxt = {{8{b8_in[7]}}, b8_in};
      end
      OP_INC16: begin
        x_nxt   = in_a;
        cin_nxt = 1'b1;
      end
      OP_DEC16: begin
        x_nxt = in_a;
        y_nxt = 16'hFFFF;
      end
      default: cin_nxt = 1'b0;
    endcase
  end

  op_t         op_s1_r;
  logic [15:0] a_s1_r;
  logic [7:0]  b_s1_r;
  logic [2:0]  bi_s1_r;
  logic [3:0]  flags_s1_r;
  logic [15:0] x_s1_r, y_s1_r;
  logic        cin_s1_r, daa_c_s1_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      op_s1_r    <= in_op;
      a_s1_r     <= in_a;
      b_s1_r     <= b8_in;
      bi_s1_r    <= in_bi;
      flags_s1_r <= {ci, hi, ni, zi};
      x_s1_r     <= x_nxt;
      y_s1_r     <= y_nxt;
      cin_s1_r   <= cin_nxt;
      daa_c_s1_r <= daa_c_nxt;
    end
  end

  // ---------------- stage two: adder and bit unit ----------------
  logic [16:0] sum_nxt;
  logic [2:0]  xy_nxt;   // x^y at bits 12, 8, 4 for carry recovery
  bitop_res_t  bop;
  logic        bitz_nxt;

  assign sum_nxt  = {1'b0, x_s1_r} + {1'b0, y_s1_r} + {16'h0000, cin_s1_r};
  assign xy_nxt   = {x_s1_r[12] ^ y_s1_r[12], x_s1_r[8] ^ y_s1_r[8],
                     x_s1_r[4] ^ y_s1_r[4]};
  assign bitz_nxt = !a_s1_r[bi_s1_r];

  cpualu_bitops u_bitops (
    .op       (op_s1_r),
    .a        (a_s1_r[7:0]),
    .b        (b_s1_r),
    .bit_sel  (bi_s1_r),
    .carry_in (flags_s1_r[3]),
    .res      (bop)
  );

  op_t         op_s2_r;
  logic [15:0] a_s2_r;
  logic [3:0]  flags_s2_r;
  logic [16:0] sum_s2_r;
  logic [2:0]  xy_s2_r;
  bitop_res_t  bop_s2_r;
  logic        bitz_s2_r, daa_c_s2_r;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      op_s2_r    <= op_s1_r;
      a_s2_r     <= a_s1_r;
      flags_s2_r <= flags_s1_r;
      sum_s2_r   <= sum_nxt;
      xy_s2_r    <= xy_nxt;
      bop_s2_r   <= bop;
      bitz_s2_r  <= bitz_nxt;
      daa_c_s2_r <= daa_c_s1_r;
    end
  end

  // ---------------- stage three: select and flags ----------------
  logic c4, c8, c12, c16;
  logic z8_sum, z8_bop;
  logic [15:0] r_nxt;
  logic        wr_nxt, z_nxt, n_nxt, h_nxt, c_nxt;

  assign c4     = xy_s2_r[0] ^ sum_s2_r[4];
  assign c8     = xy_s2_r[1] ^ sum_s2_r[8];
  assign c12    = xy_s2_r[2] ^ sum_s2_r[12];
  assign c16    = sum_s2_r[16];
  assign z8_sum = (sum_s2_r[7:0] == 8'h00);
  assign z8_bop = (bop_s2_r.value == 8'h00);

  always_comb begin
    r_nxt  = {8'h00, bop_s2_r.value};
    wr_nxt = 1'b1;
    z_nxt  = flags_s2_r[0];
    n_nxt  = flags_s2_r[1];
    h_nxt  = flags_s2_r[2];
    c_nxt  = flags_s2_r[3];
    case (op_s2_r)
      OP_ADD, OP_ADC: begin
        r_nxt = {8'h00, sum_s2_r[7:0]};
        z_nxt = z8_sum;
        n_nxt = 1'b0;
        h_nxt = c4;
        c_nxt = c8;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r_nxt  = {8'h00, sum_s2_r[7:0]};
        wr_nxt = (op_s2_r != OP_CP);
        z_nxt  = z8_sum;
        n_nxt  = 1'b1;
        h_nxt  = !c4;
        c_nxt  = !c8;
      end
      OP_AND: begin
        z_nxt = z8_bop;
        n_nxt = 1'b0;
        h_nxt = 1'b1;
        c_nxt = 1'b0;
      end
      OP_XOR, OP_OR: begin
        z_nxt = z8_bop;
        n_nxt = 1'b0;
        h_nxt = 1'b0;
        c_nxt = 1'b0;
      end
      OP_INC: begin
        r_nxt = {8'h00, sum_s2_r[7:0]};
        z_nxt = z8_sum;
        n_nxt = 1'b0;
        h_nxt = c4;
      end
      OP_DEC: begin
        r_nxt = {8'h00, sum_s2_r[7:0]};
        z_nxt = z8_sum;
        n_nxt = 1'b1;
        h_nxt = !c4;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        z_nxt = z8_bop;
        n_nxt = 1'b0;
        h_nxt = 1'b0;
        c_nxt = bop_s2_r.carry;
      end
      OP_BIT: begin
        r_nxt  = {8'h00, a_s2_r[7:0]};
        wr_nxt = 1'b0;
        z_nxt  = bitz_s2_r;
        n_nxt  = 1'b0;
        h_nxt  = 1'b1;
      end
      OP_RES, OP_SET: r_nxt = {8'h00, bop_s2_r.value};
      OP_DAA: begin
        r_nxt = {8'h00, sum_s2_r[7:0]};
        z_nxt = z8_sum;
        h_nxt = 1'b0;
        c_nxt = daa_c_s2_r;
      end
      OP_CPL: begin
        n_nxt = 1'b1;
        h_nxt = 1'b1;
      end
      OP_CCF: begin
        r_nxt = {8'h00, a_s2_r[7:0]};
        n_nxt = 1'b0;
        h_nxt = 1'b0;
        c_nxt = !flags_s2_r[3];
      end
      OP_SCF: begin
        r_nxt = {8'h00, a_s2_r[7:0]};
        n_nxt = 1'b0;
        h_nxt = 1'b0;
        c_nxt = 1'b1;
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        z_nxt = 1'b0;
        n_nxt = 1'b0;
        h_nxt = 1'b0;
        c_nxt = bop_s2_r.carry;
      end
      OP_ADD16: begin
        r_nxt = sum_s2_r[15:0];
        n_nxt = 1'b0;
        h_nxt = c12;
        c_nxt = c16;
      end
      OP_SPOFS: begin
        r_nxt = sum_s2_r[15:0];
        z_nxt = 1'b0;
        n_nxt = 1'b0;
        h_nxt = c4;
        c_nxt = c8;
      end
      OP_INC16, OP_DEC16: r_nxt = sum_s2_r[15:0];
      default: begin
        // undefined codes: pass operand and flags through, no write
        r_nxt  = a_s2_r;
        wr_nxt = 1'b0;
      end
    endcase
  end

  logic [20:0] out_r;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_r <= {c_nxt, h_nxt, n_nxt, z_nxt, wr_nxt, r_nxt};
    end
  end

  assign out_tdata = {3'b000, out_r};

  // ---------------- checks ----------------
  a_stall_holds_s2: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && v3_r && !out_tready |=> v2_r)
    else $error("stage two item lost during output stall");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted item not captured in stage one");

  a_cp_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && s3_ready && (op_s2_r == OP_CP) |=> !out_tdata[16])
    else $error("compare marked for write back");

  a_byte_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && s3_ready && (op_s2_r < OP_ADD16) |=> (out_tdata[15:8] == 8'h00))
    else $error("byte operation left upper result byte nonzero");

  a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !v2_r |=> v2_r)
    else $error("stage one item did not advance into empty stage two");

endmodule
`default_nettype wire
